// ----- rtl/mimw_pkg.sv -----
// Shared types and constants for the modulo idiom window matcher.
// Has no dependencies; every other file of the block imports it.
package mimw_pkg;

   localparam int unsigned MATCH_DEPTH = 4;

   typedef enum logic [2:0] {
      OP_OTHER = 3'd0,
      OP_AND   = 3'd1,
      OP_MUL   = 3'd2,
      OP_IMUL  = 3'd3,
      OP_SUB   = 3'd4,
      OP_SAR   = 3'd5,
      OP_SHR   = 3'd6,
      OP_ADD   = 3'd7
   } opcode_type;

   localparam logic [2:0] LEN_NONE     = 3'd0;
   localparam logic [2:0] LEN_MASK     = 3'd1;
   localparam logic [2:0] LEN_MULSUB   = 3'd2;
   localparam logic [2:0] LEN_SIGNED   = 3'd5;

   typedef struct packed {
      logic        valid;
      opcode_type  opcode;
      logic [15:0] dest;
      logic [15:0] src_a;
      logic [15:0] src_b;
      logic        is_imm;
      logic [63:0] imm;
      logic [6:0]  width;
      logic [63:0] addr;
   } entry_type;

   typedef struct packed {
      logic        found;
      logic        is_signed;
      logic [15:0] dividend_reg;
      logic [15:0] remainder_reg;
      logic [63:0] divisor;
      logic [6:0]  operand_width;
      logic [63:0] first_address;
      logic [63:0] last_address;
      logic [2:0]  length;
   } result_type;

endpackage

// ----- rtl/mimw_cell.sv -----
// One history cell: holds a decoded instruction and passes it to the next
// older cell on every accepted item. Depends on mimw_pkg.
module mimw_cell
   import mimw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  entry_type entry_in,
   output entry_type entry_out
);

   entry_type slot_ff;
   entry_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (shift_en) begin
         slot_in = entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign entry_out = slot_ff;

endmodule

// ----- rtl/mimw_match.sv -----
// Idiom matcher: compares the current instruction with the four newest
// history cells and builds one result. Depends on mimw_pkg.
module mimw_match
   import mimw_pkg::*;
(
   input  entry_type                   cur,
   input  entry_type [MATCH_DEPTH-1:0] hist,
   output result_type                  result
);

   function automatic logic is_pow2(input logic [63:0] v);
      return (v >= 64'd2) && ((v & (v - 64'd1)) == 64'd0);
   endfunction

   function automatic logic [5:0] onehot_index(input logic [63:0] v);
      logic [5:0] idx;
      idx = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            idx = idx | 6'(i);
         end
      end
      return idx;
   endfunction

   logic        mask_hit;
   logic        mul_hit;
   logic        mul_neg;
   logic        mul_big;
   logic [63:0] mask_k;
   logic        sar_ok;
   logic        shr_ok;
   logic [6:0]  shr_k;
   logic [63:0] and_k;
   logic        and_ok;
   logic        k_ok;
   logic [63:0] kval;
   logic [15:0] x_reg;
   logic        tail_ok;
   logic        signed_hit;

   always_comb begin
      mask_k   = cur.imm + 64'd1;
      mask_hit = (cur.opcode == OP_AND) && cur.is_imm && is_pow2(mask_k);

      mul_neg = hist[0].imm[63];
      mul_big = mul_neg ? (hist[0].imm != '1) : (hist[0].imm >= 64'd2);
      mul_hit = (cur.opcode == OP_SUB) && hist[0].valid
                && ((hist[0].opcode == OP_MUL) || (hist[0].opcode == OP_IMUL))
                && hist[0].is_imm && (cur.src_b == hist[0].dest) && mul_big;

      x_reg  = hist[3].src_a;
      sar_ok = hist[0].valid && hist[1].valid && hist[2].valid && hist[3].valid
               && (hist[3].opcode == OP_SAR) && hist[3].is_imm
               && (hist[3].imm == (64'(hist[3].width) - 64'd1))
               && ((hist[2].opcode == OP_SHR) || (hist[2].opcode == OP_AND))
               && (hist[2].src_a == hist[3].dest) && hist[2].is_imm;

      shr_k  = hist[3].width - hist[2].imm[6:0];
      shr_ok = (hist[3].width >= 7'd2) && (hist[2].imm != 64'd0)
               && (hist[2].imm <= (64'(hist[3].width) - 64'd1))
               && (shr_k <= 7'd63);

      and_k  = hist[2].imm + 64'd1;
      and_ok = is_pow2(and_k) && (7'(onehot_index(and_k)) < hist[3].width);

      if (hist[2].opcode == OP_SHR) begin
         k_ok = shr_ok;
         kval = 64'd1 << shr_k[5:0];
      end else begin
         k_ok = and_ok;
         kval = and_k;
      end

      tail_ok = (hist[1].opcode == OP_ADD)
                && (((hist[1].src_a == x_reg) && (hist[1].src_b == hist[2].dest))
                    || ((hist[1].src_a == hist[2].dest) && (hist[1].src_b == x_reg)))
                && (hist[0].opcode == OP_AND) && (hist[0].src_a == hist[1].dest)
                && hist[0].is_imm && (hist[0].imm == (64'd0 - kval))
                && (cur.src_a == x_reg) && (cur.src_b == hist[0].dest);

      signed_hit = (cur.opcode == OP_SUB) && sar_ok && k_ok && tail_ok;

      result = '0;
      priority if (mask_hit) begin
         result.found         = 1'b1;
         result.dividend_reg  = cur.src_a;
         result.remainder_reg = cur.dest;
         result.divisor       = mask_k;
         result.operand_width = cur.width;
         result.first_address = cur.addr;
         result.last_address  = cur.addr;
         result.length        = LEN_MASK;
      end else if (mul_hit) begin
         result.found         = 1'b1;
         result.is_signed     = mul_neg;
         result.dividend_reg  = cur.src_a;
         result.remainder_reg = cur.dest;
         result.divisor       = hist[0].imm;
         result.operand_width = hist[0].width;
         result.first_address = hist[0].addr;
         result.last_address  = cur.addr;
         result.length        = LEN_MULSUB;
      end else if (signed_hit) begin
         result.found         = 1'b1;
         result.is_signed     = 1'b1;
         result.dividend_reg  = x_reg;
         result.remainder_reg = cur.dest;
         result.divisor       = kval;
         result.operand_width = hist[3].width;
         result.first_address = hist[3].addr;
         result.last_address  = cur.addr;
         result.length        = LEN_SIGNED;
      end else begin
         result.length = LEN_NONE;
      end
   end

endmodule

// ----- rtl/modulo_idiom_window_matcher.sv -----
// Top level of the modulo idiom window matcher: a chain of history cells,
// the idiom matcher and a two-entry result buffer. Depends on mimw_pkg,
// mimw_cell and mimw_match.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | one decoded instruction
//   rsp_    | out       | rsp_valid / rsp_ready | one match result per item
//
// The result of each item is registered when the item is accepted. The matcher
// is a single combinational stage between the history cells and the result
// register, so one item per cycle is sustained while results are taken.
// A second result register absorbs one stalled result, so one more item is
// accepted while a result waits; req_ready then stays low until the waiting
// result is taken. Reset empties the history and the buffer.
module modulo_idiom_window_matcher
   import mimw_pkg::*;
#(
   parameter int unsigned HISTORY_DEPTH = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic [15:0]        req_dest_reg,
   input  logic [15:0]        req_first_src_reg,
   input  logic [15:0]        req_second_src_reg,
   input  logic               req_second_is_immediate,
   input  logic signed [63:0] req_immediate_value,
   input  logic [6:0]         req_source_width,
   input  logic [63:0]        req_instr_address,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic               rsp_is_signed,
   output logic [15:0]        rsp_dividend_reg,
   output logic [15:0]        rsp_remainder_reg,
   output logic signed [63:0] rsp_divisor,
   output logic [6:0]         rsp_operand_width,
   output logic [63:0]        rsp_first_address,
   output logic [63:0]        rsp_last_address,
   output logic [2:0]         rsp_length
);

   entry_type                     cur;
   entry_type [HISTORY_DEPTH:0]   chain;
   result_type                    match_result;
   logic                          push;
   logic                          pop;

   result_type out_ff;
   result_type out_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type skid_ff;
   result_type skid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;

   always_comb begin
      cur.valid  = 1'b1;
      cur.opcode = opcode_type'(req_opcode);
      cur.dest   = req_dest_reg;
      cur.src_a  = req_first_src_reg;
      cur.src_b  = req_second_src_reg;
      cur.is_imm = req_second_is_immediate;
      cur.imm    = req_immediate_value;
      cur.width  = req_source_width;
      cur.addr   = req_instr_address;
   end

   assign chain[0] = cur;
   assign push     = req_valid && req_ready;
   assign pop      = out_valid_ff && rsp_ready;

   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      mimw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (push),
         .entry_in  (chain[g]),
         .entry_out (chain[g+1])
      );
   end

   mimw_match u_match (
      .cur    (cur),
      .hist   (chain[MATCH_DEPTH:1]),
      .result (match_result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = match_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = match_result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign req_ready         = !skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_ff.found;
   assign rsp_is_signed     = out_ff.is_signed;
   assign rsp_dividend_reg  = out_ff.dividend_reg;
   assign rsp_remainder_reg = out_ff.remainder_reg;
   assign rsp_divisor       = out_ff.divisor;
   assign rsp_operand_width = out_ff.operand_width;
   assign rsp_first_address = out_ff.first_address;
   assign rsp_last_address  = out_ff.last_address;
   assign rsp_length        = out_ff.length;

endmodule

// ----- rtl/mimw_checker.sv -----
// Port-level checks for the modulo idiom window matcher, bound to the top
// level. Depends on mimw_pkg and modulo_idiom_window_matcher.
module mimw_checker
   import mimw_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_found,
   input logic               rsp_is_signed,
   input logic signed [63:0] rsp_divisor,
   input logic [63:0]        rsp_first_address,
   input logic [63:0]        rsp_last_address,
   input logic [2:0]         rsp_length
);

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_item_shows_next_cycle : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> rsp_valid)
      else $error("accepted item gave no result in the next cycle");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_length)
                                     && $stable(rsp_divisor)))
      else $error("stalled result changed");

   a_no_match_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_length == LEN_NONE && rsp_divisor == 64'sd0
                                     && !rsp_is_signed))
      else $error("empty result carries data");

   a_match_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         ((rsp_length == LEN_MASK && rsp_first_address == rsp_last_address
           && !rsp_is_signed)
          || rsp_length == LEN_MULSUB
          || (rsp_length == LEN_SIGNED && rsp_is_signed)))
      else $error("match has an impossible kind");

endmodule

bind modulo_idiom_window_matcher mimw_checker u_mimw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_found         (rsp_found),
   .rsp_is_signed     (rsp_is_signed),
   .rsp_divisor       (rsp_divisor),
   .rsp_first_address (rsp_first_address),
   .rsp_last_address  (rsp_last_address),
   .rsp_length        (rsp_length)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for modulo_idiom_window_matcher.
// Drives decoded instructions with random gaps and stalls, and checks each match result
// against a cycle-free predictor of the window matcher. Depends on mimw_pkg and the RTL.
module tb_top;
   import mimw_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_OFF_AT = 500;
   localparam int unsigned HOLD_OFF_CYCLES = 250;
   localparam int unsigned TOTAL_ITEMS = 1025;

   typedef struct {
      opcode_type  opcode;
      logic [15:0] dest;
      logic [15:0] src_a;
      logic [15:0] src_b;
      logic        is_imm;
      logic [63:0] imm;
      logic [6:0]  width;
      logic [63:0] addr;
      int unsigned gap;
      bit          drain;
   } instr_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_opcode = '0;
   logic [15:0]        req_dest_reg = '0;
   logic [15:0]        req_first_src_reg = '0;
   logic [15:0]        req_second_src_reg = '0;
   logic               req_second_is_immediate = 1'b0;
   logic signed [63:0] req_immediate_value = '0;
   logic [6:0]         req_source_width = '0;
   logic [63:0]        req_instr_address = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_found;
   logic               rsp_is_signed;
   logic [15:0]        rsp_dividend_reg;
   logic [15:0]        rsp_remainder_reg;
   logic signed [63:0] rsp_divisor;
   logic [6:0]         rsp_operand_width;
   logic [63:0]        rsp_first_address;
   logic [63:0]        rsp_last_address;
   logic [2:0]         rsp_length;

   instr_item_type pending_instrs[$];
   instr_item_type current_instr;
   result_type     expected_matches[$];
   entry_type      window[MATCH_DEPTH];
   logic [63:0]    next_address = '0;
   bit             drain_next = 1'b0;
   int unsigned    gap_left = 0;
   int unsigned    stall_left = 0;
   int unsigned    results_seen = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    fail_count = 0;

   modulo_idiom_window_matcher dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_opcode              (req_opcode),
      .req_dest_reg            (req_dest_reg),
      .req_first_src_reg       (req_first_src_reg),
      .req_second_src_reg      (req_second_src_reg),
      .req_second_is_immediate (req_second_is_immediate),
      .req_immediate_value     (req_immediate_value),
      .req_source_width        (req_source_width),
      .req_instr_address       (req_instr_address),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_found               (rsp_found),
      .rsp_is_signed           (rsp_is_signed),
      .rsp_dividend_reg        (rsp_dividend_reg),
      .rsp_remainder_reg       (rsp_remainder_reg),
      .rsp_divisor             (rsp_divisor),
      .rsp_operand_width       (rsp_operand_width),
      .rsp_first_address       (rsp_first_address),
      .rsp_last_address        (rsp_last_address),
      .rsp_length              (rsp_length)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit is_power_of_two(logic [63:0] v);
      return v >= 64'd2 && (v & (v - 64'd1)) == 64'd0;
   endfunction

   // Works out the match that ends at this instruction, then shifts it into the window.
   function automatic result_type predict_modulo_idiom(instr_item_type ins);
      result_type  r;
      logic [63:0] factor;
      logic [63:0] n;
      logic [63:0] sh;
      logic [63:0] kk;
      logic [63:0] kval;
      logic [15:0] x;
      bit          ok;
      int          top_bit;
      r = '0;
      ok = 1'b0;
      kval = '0;
      top_bit = 0;
      if (ins.opcode == OP_AND && ins.is_imm && is_power_of_two(ins.imm + 64'd1)) begin
         r.found = 1'b1;
         r.dividend_reg = ins.src_a;
         r.remainder_reg = ins.dest;
         r.divisor = ins.imm + 64'd1;
         r.operand_width = ins.width;
         r.first_address = ins.addr;
         r.last_address = ins.addr;
         r.length = LEN_MASK;
      end else if (ins.opcode == OP_SUB && window[0].valid &&
                   (window[0].opcode == OP_MUL || window[0].opcode == OP_IMUL) &&
                   window[0].is_imm && ins.src_b == window[0].dest) begin
         factor = window[0].imm;
         if (factor[63] ? (factor != '1) : (factor >= 64'd2)) begin
            r.found = 1'b1;
            r.is_signed = factor[63];
            r.dividend_reg = ins.src_a;
            r.remainder_reg = ins.dest;
            r.divisor = factor;
            r.operand_width = window[0].width;
            r.first_address = window[0].addr;
            r.last_address = ins.addr;
            r.length = LEN_MULSUB;
         end
      end
      if (!r.found && ins.opcode == OP_SUB && window[0].valid && window[1].valid &&
          window[2].valid && window[3].valid && window[3].opcode == OP_SAR &&
          window[3].is_imm && window[3].imm == {57'd0, window[3].width} - 64'd1 &&
          (window[2].opcode == OP_SHR || window[2].opcode == OP_AND) &&
          window[2].src_a == window[3].dest && window[2].is_imm) begin
         n = {57'd0, window[3].width};
         x = window[3].src_a;
         if (window[2].opcode == OP_SHR) begin
            sh = window[2].imm;
            if (n >= 64'd2 && sh >= 64'd1 && sh <= n - 64'd1 && n - sh <= 64'd63) begin
               kval = 64'd1 << (n - sh);
               ok = 1'b1;
            end
         end else begin
            kk = window[2].imm + 64'd1;
            for (int b = 0; b < 64; b++)
               if (kk[b]) top_bit = b;
            if (is_power_of_two(kk) && top_bit < n) begin
               kval = kk;
               ok = 1'b1;
            end
         end
         if (ok && window[1].opcode == OP_ADD &&
             ((window[1].src_a == x && window[1].src_b == window[2].dest) ||
              (window[1].src_a == window[2].dest && window[1].src_b == x)) &&
             window[0].opcode == OP_AND && window[0].src_a == window[1].dest &&
             window[0].is_imm && window[0].imm == 64'd0 - kval &&
             ins.src_a == x && ins.src_b == window[0].dest) begin
            r.found = 1'b1;
            r.is_signed = 1'b1;
            r.dividend_reg = x;
            r.remainder_reg = ins.dest;
            r.divisor = kval;
            r.operand_width = n[6:0];
            r.first_address = window[3].addr;
            r.last_address = ins.addr;
            r.length = LEN_SIGNED;
         end
      end
      for (int i = MATCH_DEPTH - 1; i > 0; i--)
         window[i] = window[i - 1];
      window[0].valid = 1'b1;
      window[0].opcode = ins.opcode;
      window[0].dest = ins.dest;
      window[0].src_a = ins.src_a;
      window[0].src_b = ins.src_b;
      window[0].is_imm = ins.is_imm;
      window[0].imm = ins.imm;
      window[0].width = ins.width;
      window[0].addr = ins.addr;
      return r;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] pick_reg();
      return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
   endfunction

   function automatic logic [6:0] pick_width();
      return 7'($urandom_range(0, 64));
   endfunction

   function automatic void add_instr(opcode_type op, logic [15:0] dst, logic [15:0] sa,
                                     logic [15:0] sb, logic is_imm, logic [63:0] imm,
                                     logic [6:0] width);
      instr_item_type it;
      int unsigned    roll;
      it.opcode = op;
      it.dest = dst;
      it.src_a = sa;
      it.src_b = sb;
      it.is_imm = is_imm;
      it.imm = imm;
      it.width = width;
      it.addr = next_address;
      it.drain = drain_next;
      drain_next = 1'b0;
      next_address = ($urandom_range(0, 99) < 5) ? random_word() :
                     next_address + 64'($urandom_range(1, 15));
      roll = $urandom_range(0, 99);
      if ((pending_instrs.size() / 120) % 3 == 1 || roll < 70)
         it.gap = 0;
      else if (roll < 95)
         it.gap = $urandom_range(1, 3);
      else
         it.gap = $urandom_range(8, 40);
      pending_instrs.push_back(it);
   endfunction

   function automatic void add_mul_sub(logic [63:0] factor, logic imul, logic is_imm,
                                       logic linked);
      logic [15:0] product;
      product = pick_reg();
      add_instr(imul ? OP_IMUL : OP_MUL, product, pick_reg(), pick_reg(), is_imm, factor,
                pick_width());
      add_instr(OP_SUB, pick_reg(), pick_reg(), linked ? product : pick_reg(),
                1'($urandom_range(0, 1)), random_word(), pick_width());
   endfunction

   // Signed power-of-two remainder: SAR, SHR or AND, ADD, AND with -K, SUB.
   // A nonzero flaw breaks one link of the chain.
   function automatic void add_signed_mod(logic [6:0] n, int unsigned k, logic use_shr,
                                          logic swap, int unsigned flaw);
      logic [15:0] x, t0, t1, t2, t3, add_a, sub_a, sub_b;
      logic [63:0] sar_imm, step_imm, neg_k;
      opcode_type  step_op;
      x = pick_reg();
      t0 = pick_reg();
      t1 = pick_reg();
      t2 = pick_reg();
      t3 = pick_reg();
      sar_imm = {57'd0, n} - 64'd1;
      step_imm = use_shr ? {57'd0, n} - 64'(k) : (64'd1 << k) - 64'd1;
      neg_k = 64'd0 - (64'd1 << k);
      step_op = use_shr ? OP_SHR : OP_AND;
      add_a = pick_reg();
      sub_a = x;
      sub_b = t3;
      case (flaw)
         1: sar_imm = sar_imm + 64'd1;
         2: step_imm = use_shr ? (($urandom_range(0, 1) != 0) ? {57'd0, n} : '1)
                               : ((64'd1 << n) - 64'd1);
         3: step_imm = random_word();
         4: x = x ^ 16'd1;
         5: neg_k = random_word();
         6: sub_a = pick_reg();
         7: sub_b = pick_reg();
         8: step_op = OP_SUB;
         default: ;
      endcase
      add_instr(OP_SAR, t0, x, pick_reg(), 1'b1, sar_imm, n);
      add_instr(step_op, t1, t0, pick_reg(), 1'b1, step_imm, pick_width());
      if (flaw == 4) x = x ^ 16'd1;
      if (flaw == 9)
         add_instr(OP_ADD, t2, add_a, t1, 1'b0, random_word(), pick_width());
      else
         add_instr(OP_ADD, t2, swap ? t1 : x, swap ? x : t1, 1'($urandom_range(0, 1)),
                   random_word(), pick_width());
      if (flaw == 10)
         add_instr(OP_OTHER, pick_reg(), pick_reg(), pick_reg(), 1'b0, random_word(),
                   pick_width());
      add_instr(OP_AND, t3, t2, pick_reg(), 1'b1, neg_k, pick_width());
      add_instr(OP_SUB, pick_reg(), sub_a, sub_b, 1'($urandom_range(0, 1)), random_word(),
                pick_width());
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      logic launch;
      launch = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_matches.push_back(predict_modulo_idiom(current_instr));
            gap_left = current_instr.gap;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_instrs.size() != 0 &&
                         (!pending_instrs[0].drain || expected_matches.size() == 0)) begin
               current_instr = pending_instrs.pop_front();
               launch = 1'b1;
               req_opcode <= current_instr.opcode;
               req_dest_reg <= current_instr.dest;
               req_first_src_reg <= current_instr.src_a;
               req_second_src_reg <= current_instr.src_b;
               req_second_is_immediate <= current_instr.is_imm;
               req_immediate_value <= current_instr.imm;
               req_source_width <= current_instr.width;
               req_instr_address <= current_instr.addr;
            end
            req_valid <= launch;
         end
      end
   end

   always @(posedge clock) begin
      result_type  want;
      int unsigned roll;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_matches.size() == 0) begin
               $error("result with no item outstanding");
               fail_count++;
            end else begin
               want = expected_matches.pop_front();
               check_field("found", 64'(want.found), 64'(rsp_found));
               check_field("is_signed", 64'(want.is_signed), 64'(rsp_is_signed));
               check_field("dividend_reg", 64'(want.dividend_reg), 64'(rsp_dividend_reg));
               check_field("remainder_reg", 64'(want.remainder_reg),
                           64'(rsp_remainder_reg));
               check_field("divisor", want.divisor, rsp_divisor);
               check_field("operand_width", 64'(want.operand_width),
                           64'(rsp_operand_width));
               check_field("first_address", want.first_address, rsp_first_address);
               check_field("last_address", want.last_address, rsp_last_address);
               check_field("length", 64'(want.length), 64'(rsp_length));
            end
            if (results_seen == HOLD_OFF_AT) stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left == 0 && (results_seen / 100) % 4 != 0) begin
            roll = $urandom_range(0, 99);
            if (roll >= 95)
               stall_left = $urandom_range(10, 40);
            else if (roll >= 75)
               stall_left = $urandom_range(1, 3);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int unsigned pick;
      int unsigned k;
      logic [6:0]  n;
      logic [63:0] factor;
      bit          second_drain;
      second_drain = 1'b0;
      for (int i = 0; i < MATCH_DEPTH; i++) window[i] = '0;

      // A SUB right after reset must not pair with the empty window.
      add_instr(OP_SUB, 16'd1, 16'd2, 16'd0, 1'b0, '0, 7'd64);
      add_instr(OP_AND, 16'd5, 16'd6, 16'hFFFF, 1'b1, 64'd1, 7'd64);
      next_address = '1;
      add_instr(OP_AND, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 7'd1);
      add_instr(OP_AND, 16'd3, 16'd4, 16'd5, 1'b1, '1, 7'd32);
      add_mul_sub(64'd2, 1'b0, 1'b1, 1'b1);
      add_mul_sub(64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1);
      add_mul_sub('1, 1'b1, 1'b1, 1'b1);
      add_signed_mod(7'd64, 63, 1'b1, 1'b0, 0);
      add_signed_mod(7'd8, 2, 1'b0, 1'b1, 0);
      // Width zero makes N-1 all ones and leaves no valid power.
      add_signed_mod(7'd0, 1, 1'b0, 1'b0, 0);

      drain_next = 1'b1;
      while (pending_instrs.size() < TOTAL_ITEMS) begin
         if (pending_instrs.size() >= 700 && !second_drain) begin
            drain_next = 1'b1;
            second_drain = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            k = $urandom_range(1, 64);
            factor = (k == 64) ? '1 : (64'd1 << k) - 64'd1;
            if ($urandom_range(0, 4) == 0) factor = random_word();
            add_instr(OP_AND, pick_reg(), pick_reg(), pick_reg(),
                      1'($urandom_range(0, 5) != 0), factor, pick_width());
         end else if (pick < 45) begin
            case ($urandom_range(0, 3))
               0: factor = 64'($urandom_range(0, 100));
               1: factor = 64'd0 - 64'($urandom_range(0, 100));
               2: factor = ($urandom_range(0, 1) != 0) ? 64'h8000_0000_0000_0000
                                                      : 64'h7FFF_FFFF_FFFF_FFFF;
               default: factor = random_word();
            endcase
            add_mul_sub(factor, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 7) != 0),
                        1'($urandom_range(0, 7) != 0));
         end else if (pick < 80) begin
            n = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 1))
                                            : 7'($urandom_range(2, 64));
            k = (n >= 2) ? $urandom_range(1, n - 1) : 1;
            add_signed_mod(n, k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0);
         end else begin
            repeat ($urandom_range(1, 3))
               add_instr(opcode_type'(3'($urandom_range(0, 7))), 16'($urandom),
                         16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                         random_word(), pick_width());
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      do
         @(negedge clock);
      while (!(pending_instrs.size() == 0 && !req_valid && expected_matches.size() == 0) &&
             idle_cycles < WATCHDOG_LIMIT);
      if (idle_cycles < WATCHDOG_LIMIT) repeat (8) @(negedge clock);
      if (idle_cycles < WATCHDOG_LIMIT && fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
